// ===== rtl/pci_pkg.sv =====
// Shared types for the palette color indexer.
package pci_pkg;

	localparam int ColorW = 32;

	typedef struct packed {
		logic              vld;
		logic              last;
		logic              transp;
		logic              done;
		logic              is_new;
		logic [ColorW-1:0] color;
	} pix_t;

endpackage

// ===== rtl/palette_color_indexer.sv =====
// Palette color indexer top level: a chain of palette cells.
//
//  channel | dir | tdata                           | tuser                     | tlast
//  s_*     | in  | red, green, blue, alpha         | -                         | last_pixel
//  m_*     | out | color_index[3:0], count[8:4]    | transp, new, overflow     | end_of_image
//
// Each pixel walks the chain through every cell's register in turn; one pixel per
// cycle sustained while the output is not stalled; the chain's length sets the latency.
// The last cell's stage is the output register.
// A stalled output freezes the whole chain; s_tready follows it.
// Reset empties every cell at once.
module palette_color_indexer #(
	parameter int PALETTE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red, green, blue, alpha
	input  logic        s_tlast,   // last_pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // color_index[3:0], color_count[8:4], zero
	output logic [2:0]  m_tuser,   // transparent, new_color, overflow
	output logic        m_tlast    // end_of_image
);
	import pci_pkg::*;

	localparam int IW = $clog2(PALETTE_DEPTH);
	localparam int CW = $clog2(PALETTE_DEPTH+1);

	pix_t          pix_c [PALETTE_DEPTH+1];
	logic [IW-1:0] idx_c [PALETTE_DEPTH+1];
	logic [CW-1:0] cnt_c [PALETTE_DEPTH+1];
	logic          en;
	pix_t          head;
	pix_t          tail;
	logic [IW+3:0] idx_wide;
	logic [CW+4:0] cnt_wide;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		head.vld    = s_tvalid;
		head.last   = s_tlast;
		head.transp = (s_tdata[31:24] == 8'd0);
		head.done   = 1'b0;
		head.is_new = 1'b0;
		head.color  = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
	end

	assign pix_c[0] = head;
	assign idx_c[0] = '0;
	assign cnt_c[0] = '0;

	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		pci_cell #(
			.DEPTH    (PALETTE_DEPTH),
			.CELL_IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.pix_in  (pix_c[i]),
			.idx_in  (idx_c[i]),
			.cnt_in  (cnt_c[i]),
			.pix_out (pix_c[i+1]),
			.idx_out (idx_c[i+1]),
			.cnt_out (cnt_c[i+1])
		);
	end

	assign tail     = pix_c[PALETTE_DEPTH];
	assign idx_wide = {4'd0, idx_c[PALETTE_DEPTH]};
	assign cnt_wide = {5'd0, cnt_c[PALETTE_DEPTH]};

	assign m_tvalid = tail.vld;
	assign m_tlast  = tail.last;
	assign m_tdata  = {7'd0, cnt_wide[4:0], idx_wide[3:0]};
	assign m_tuser  = {!tail.transp && !tail.done, tail.is_new, tail.transp};

`ifndef SYNTHESIS
	a_new_count : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && tail.is_new) |-> (cnt_c[PALETTE_DEPTH] == CW'(idx_c[PALETTE_DEPTH]) + CW'(1)))
		else $error("new entry index disagrees with count");

	a_ovf_full : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (cnt_c[PALETTE_DEPTH] == CW'(PALETTE_DEPTH)))
		else $error("overflow with palette not full");

	a_cnt_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt_c[PALETTE_DEPTH] <= CW'(PALETTE_DEPTH)))
		else $error("count beyond palette depth");

	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output transaction changed while stalled");
`endif

endmodule

// ===== rtl/pci_cell.sv =====
// One palette cell: holds one entry, matches or claims it, passes the pixel on.
module pci_cell #(
	parameter int DEPTH    = 16,
	parameter int CELL_IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  pci_pkg::pix_t                pix_in,
	input  logic [$clog2(DEPTH)-1:0]     idx_in,
	input  logic [$clog2(DEPTH+1)-1:0]   cnt_in,
	output pci_pkg::pix_t                pix_out,
	output logic [$clog2(DEPTH)-1:0]     idx_out,
	output logic [$clog2(DEPTH+1)-1:0]   cnt_out
);
	import pci_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic              valid_q;
	logic [ColorW-1:0] entry_q;
	pix_t              pix_s1;
	logic [IW-1:0]     idx_s1;
	logic [CW-1:0]     cnt_s1;

	logic active, hit, alloc, valid_after;
	pix_t pix_nxt;

	always_comb begin
		active      = pix_in.vld && !pix_in.transp && !pix_in.done;
		hit         = active && valid_q && (entry_q == pix_in.color);
		alloc       = active && !valid_q;
		valid_after = valid_q || alloc;
		pix_nxt        = pix_in;
		pix_nxt.done   = pix_in.done || hit || alloc;
		pix_nxt.is_new = pix_in.is_new || alloc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pix_s1  <= '0;
		end else if (en) begin
			pix_s1 <= pix_nxt;
			if (pix_in.vld && pix_in.last) begin
				valid_q <= 1'b0;
			end else if (alloc) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (alloc) begin
				entry_q <= pix_in.color;
			end
			idx_s1        <= (hit || alloc) ? IW'(CELL_IDX) : idx_in;
			cnt_s1        <= (pix_in.vld && valid_after) ? cnt_in + CW'(1) : cnt_in;
		end
	end

	assign pix_out = pix_s1;
	assign idx_out = idx_s1;
	assign cnt_out = cnt_s1;

endmodule
